// ===== design/log_peak_requests_in_window_top_macros.svh =====
// Assertion helpers used by lprw_dp.
`ifndef LOG_PEAK_REQUESTS_IN_WINDOW_TOP_MACROS_SVH
`define LOG_PEAK_REQUESTS_IN_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lprw_pkg.sv =====
// ----------------------------------------------------------------------------
// lprw_pkg
// Shared types and constants for the log peak request window block.
// ----------------------------------------------------------------------------
package lprw_pkg;

    localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [7:0]  CH_LBRACKET = 8'h5B;
    localparam logic [7:0]  CH_COLON    = 8'h3A;
    localparam logic [7:0]  CH_ZERO     = 8'h30;
    localparam logic [7:0]  CH_NINE     = 8'h39;

    localparam logic [21:0] SECONDS_CAP    = 22'd2678400;
    localparam logic [21:0] WINDOW_RESET   = 22'd60;
    localparam logic [8:0]  COLUMN_CAP     = 9'd511;
    localparam logic [16:0] SECONDS_DAY    = 17'd86400;
    localparam logic [11:0] SECONDS_HOUR   = 12'd3600;
    localparam logic [5:0]  SECONDS_MINUTE = 6'd60;

    // capture phase / capture target codes
    localparam logic [2:0] PH_DAY    = 3'd0;
    localparam logic [2:0] PH_HOUR   = 3'd1;
    localparam logic [2:0] PH_MINUTE = 3'd2;
    localparam logic [2:0] PH_SECOND = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // digit position codes
    localparam logic [1:0] DP_IDLE   = 2'd0;
    localparam logic [1:0] DP_TENS   = 2'd1;
    localparam logic [1:0] DP_UNITS  = 2'd2;

    typedef struct packed {
        logic take;     // byte request accepted this cycle
        logic calc;     // form day and time-of-day terms
        logic push;     // write line time into store
        logic rd;       // read oldest entry
        logic evict;    // drop oldest entry
        logic finish;   // update peak, load result register
    } t_dp_cmd;

    typedef struct packed {
        logic newline;  // current input byte ends a line
        logic multi;    // more than one entry held
        logic evict_ok; // oldest entry lies outside the window
        logic out_free; // result register can take a new result
    } t_dp_sts;

endpackage

// ===== design/log_peak_requests_in_window_top.sv =====
// ----------------------------------------------------------------------------
// log_peak_requests_in_window_top
// Peak request count within a sliding time window over a log byte stream.
//
// Input channel: one text byte per request (i_in_valid / o_in_ready).
// Output channel: one result per newline (o_out_valid / i_out_ready) with
// the line time, the count of lines inside the window and the running peak.
// Config: i_cfg_we / i_cfg_wdata writes the window span in seconds.
// Non-newline bytes are taken one per cycle. A newline starts the line
// sequence: time calculation and push, then a store read and compare
// per evicted entry, plus a final check while more than one entry is
// held, then the result load; the timestamp store has a single read port.
// Bytes are not taken during that sequence.
// A waiting result does not block byte intake; a new result waits in the
// load step while the receiver stalls the previous one.
// Reset clears the parser, counts and pointers and sets the window to 60;
// the store needs no clearing, only held entries are ever read.
// ----------------------------------------------------------------------------
module log_peak_requests_in_window_top #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int START_COLUMN = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [21:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [21:0] o_line_seconds,
    output logic [10:0] o_window_count,
    output logic [10:0] o_peak_count,
    output logic        o_store_overflow
);
    import lprw_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lprw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lprw_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .START_COLUMN (START_COLUMN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_text_byte      (i_text_byte),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_line_seconds   (o_line_seconds),
        .o_window_count   (o_window_count),
        .o_peak_count     (o_peak_count),
        .o_store_overflow (o_store_overflow)
    );

endmodule

// ===== design/lprw_ram.sv =====
// ----------------------------------------------------------------------------
// lprw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lprw_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lprw_ctrl.sv =====
// ----------------------------------------------------------------------------
// lprw_ctrl
// Sequencer: byte intake, line time calculation, push, eviction loop and result load.
// ----------------------------------------------------------------------------
module lprw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lprw_pkg::t_dp_sts i_sts,
    output lprw_pkg::t_dp_cmd o_cmd
);
    import lprw_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.newline) begin
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                if (i_sts.multi) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end else begin
                    n_state  = S_DONE;
                end
            end
            S_CMP: begin
                if (i_sts.evict_ok) begin
                    o_cmd.evict = 1'b1;
                    n_state     = S_READ;
                end else begin
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/lprw_dp.sv =====
// ----------------------------------------------------------------------------
// lprw_dp
// Datapath: line parser, time calculation, timestamp store, counts, result.
// ----------------------------------------------------------------------------
`include "log_peak_requests_in_window_top_macros.svh"

module lprw_dp #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int START_COLUMN = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [21:0]       i_cfg_wdata,
    input  logic [7:0]        i_text_byte,
    input  lprw_pkg::t_dp_cmd i_cmd,
    output lprw_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [21:0]       o_line_seconds,
    output logic [10:0]       o_window_count,
    output logic [10:0]       o_peak_count,
    output logic              o_store_overflow
);
    import lprw_pkg::*;

    localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int OW = (CW > 11) ? CW : 11;

    // parser state
    logic [8:0]  r_col,    n_col;
    logic [2:0]  r_phase,  n_phase;
    logic [1:0]  r_dpos,   n_dpos;
    logic [2:0]  r_target, n_target;
    logic [6:0]  r_day,    n_day;
    logic [6:0]  r_hour,   n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;

    logic [21:0] r_window;
    logic [23:0] r_day_term;
    logic [18:0] r_rest_term;
    logic [21:0] r_t;
    logic        r_ovf;

    logic [PW-1:0] r_oldest;
    logic [PW-1:0] r_newest;
    logic [CW-1:0] r_entries;
    logic [CW-1:0] r_peak;

    logic        r_out_valid;
    logic [21:0] r_out_seconds;
    logic [10:0] r_out_count;
    logic [10:0] r_out_peak;
    logic        r_out_ovf;

    logic [3:0]  w_digit;
    logic [6:0]  w_cur_val;
    logic [6:0]  w_cap_val;
    logic        w_cap_we;
    logic        w_at_start;
    logic [24:0] w_sum;
    logic [21:0] w_t;
    logic        w_full;
    logic [21:0] w_old;
    logic [CW-1:0] w_new_peak;
    logic [OW-1:0] w_count_ext;
    logic [OW-1:0] w_peak_ext;

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] ptr);
        logic [PW-1:0] res;
        if (ptr == PW'(WINDOW_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PW'(1);
        end
        return res;
    endfunction

    // ---------------- parser ----------------
    assign w_digit    = (i_text_byte >= CH_ZERO && i_text_byte <= CH_NINE) ?
                        4'(i_text_byte - CH_ZERO) : 4'd0;
    assign w_at_start = (r_col >= 9'(START_COLUMN));

    always_comb begin
        case (r_target)
            PH_DAY:    w_cur_val = r_day;
            PH_HOUR:   w_cur_val = r_hour;
            PH_MINUTE: w_cur_val = r_minute;
            default:   w_cur_val = r_second;
        endcase
    end

    always_comb begin
        n_col     = r_col;
        n_phase   = r_phase;
        n_dpos    = r_dpos;
        n_target  = r_target;
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_second  = r_second;
        w_cap_we  = 1'b0;
        w_cap_val = '0;
        if (i_cmd.take) begin
            if (i_text_byte == CH_NEWLINE) begin
                n_col   = '0;
                n_phase = PH_DAY;
                n_dpos  = DP_IDLE;
            end else begin
                if (r_dpos == DP_TENS) begin
                    w_cap_we  = 1'b1;
                    w_cap_val = 7'(w_digit) * 7'd10;
                    n_dpos    = DP_UNITS;
                end else if (r_dpos == DP_UNITS) begin
                    w_cap_we  = 1'b1;
                    w_cap_val = w_cur_val + 7'(w_digit);
                    n_dpos    = DP_IDLE;
                end else if (w_at_start) begin
                    if (i_text_byte == CH_LBRACKET && r_phase == PH_DAY) begin
                        w_cap_we = 1'b1;
                        n_target = PH_DAY;
                        n_dpos   = DP_TENS;
                        n_phase  = PH_HOUR;
                    end else if (i_text_byte == CH_COLON &&
                                 (r_phase == PH_HOUR || r_phase == PH_MINUTE ||
                                  r_phase == PH_SECOND)) begin
                        w_cap_we = 1'b1;
                        n_target = r_phase;
                        n_dpos   = DP_TENS;
                        n_phase  = r_phase + 3'd1;
                    end
                end
                if (r_col < COLUMN_CAP) begin
                    n_col = r_col + 9'd1;
                end
            end
        end
        if (w_cap_we) begin
            case (n_target)
                PH_DAY:    n_day    = w_cap_val;
                PH_HOUR:   n_hour   = w_cap_val;
                PH_MINUTE: n_minute = w_cap_val;
                default:   n_second = w_cap_val;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_phase  <= PH_DAY;
            r_dpos   <= DP_IDLE;
            r_target <= PH_DAY;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else begin
            r_col    <= n_col;
            r_phase  <= n_phase;
            r_dpos   <= n_dpos;
            r_target <= n_target;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // ---------------- line time ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_day_term  <= (r_day == 7'd0) ? 24'd0 :
                           24'(7'(r_day - 7'd1)) * 24'(SECONDS_DAY);
            r_rest_term <= 19'(r_hour) * 19'(SECONDS_HOUR) +
                           19'(r_minute) * 19'(SECONDS_MINUTE) + 19'(r_second);
        end
    end

    assign w_sum = 25'(r_day_term) + 25'(r_rest_term);
    assign w_t   = (w_sum > 25'(SECONDS_CAP)) ? SECONDS_CAP : w_sum[21:0];

    // ---------------- timestamp store ----------------
    lprw_ram #(
        .WIDTH (22),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_newest),
        .i_wdata (w_t),
        .i_re    (i_cmd.rd),
        .i_raddr (r_oldest),
        .o_rdata (w_old)
    );

    assign w_full = (r_entries >= CW'(WINDOW_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_oldest  <= '0;
            r_newest  <= '0;
            r_entries <= '0;
            r_peak    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_newest <= f_adv(r_newest);
                if (w_full) begin
                    r_oldest <= f_adv(r_oldest);
                end else begin
                    r_entries <= r_entries + CW'(1);
                end
            end else if (i_cmd.evict) begin
                r_oldest  <= f_adv(r_oldest);
                r_entries <= r_entries - CW'(1);
            end
            if (i_cmd.finish) begin
                r_peak <= w_new_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_t   <= w_t;
            r_ovf <= w_full;
        end
    end

    // ---------------- result register ----------------
    assign w_new_peak  = (r_entries > r_peak) ? r_entries : r_peak;
    assign w_count_ext = OW'(r_entries);
    assign w_peak_ext  = OW'(w_new_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_seconds <= r_t;
            r_out_count   <= w_count_ext[10:0];
            r_out_peak    <= w_peak_ext[10:0];
            r_out_ovf     <= r_ovf;
        end
    end

    assign o_sts.newline  = (i_text_byte == CH_NEWLINE);
    assign o_sts.multi    = (r_entries > CW'(1));
    assign o_sts.evict_ok = (r_t > w_old) && ((r_t - w_old) > r_window);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_line_seconds   = r_out_seconds;
    assign o_window_count   = r_out_count;
    assign o_peak_count     = r_out_peak;
    assign o_store_overflow = r_out_ovf;

    `LPRW_ASSERT_NOW(a_entries_bound, i_clk, i_rst_n, 1'b1, r_entries <= CW'(WINDOW_DEPTH), "entry count above store depth")
    `LPRW_ASSERT_NOW(a_evict_keeps_one, i_clk, i_rst_n, i_cmd.evict, r_entries > CW'(1), "eviction would empty the store")
    `LPRW_ASSERT_NEXT(a_peak_covers, i_clk, i_rst_n, i_cmd.finish, r_peak >= r_entries, "peak below current count")
    `LPRW_ASSERT_NOW(a_seconds_cap, i_clk, i_rst_n, r_out_valid, r_out_seconds <= SECONDS_CAP, "line time above saturation")

endmodule
